@@ hdl/ils_pkg.sv @@
// Shared types and constants for the integer literal scanner.
// Used by the scan logic, the top level and the testbench; no dependencies.
`default_nettype none

package ils_pkg;

  localparam int VALUE_W = 64;
  localparam int LEN_W   = 8;

  // Scan mode codes.
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_SIGN = 3'd1;
  localparam logic [2:0] MODE_ZERO = 3'd2;
  localparam logic [2:0] MODE_HEX  = 3'd3;
  localparam logic [2:0] MODE_DEC  = 3'd4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LONG  = 8'h4c;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_HEX_X = 8'h78;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               negative;
    logic [VALUE_W-1:0] acc;
    logic [LEN_W-1:0]   consumed;
  } scan_state_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [VALUE_W-1:0] value;
    logic [LEN_W-1:0]          length;
  } result_t;

  // Returns {is_hex_digit, digit value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                 (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ils_char_if.sv @@
// Character input channel: valid/ready handshake with one character item.
// Depends on nothing.
`default_nettype none

interface ils_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ hdl/ils_result_if.sv @@
// Result output channel: valid/ready handshake with one scanned literal item.
// Depends on nothing.
`default_nettype none

interface ils_result_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [63:0] value;
  logic [7:0]         length;

  modport source (output valid, output accepted, output value, output length, input ready);
  modport sink   (input valid, input accepted, input value, input length, output ready);
endinterface

`default_nettype wire

@@ hdl/ils_char_stage.sv @@
// Input register for the character channel.
// Depends on ils_pkg and ils_char_if.
`default_nettype none

module ils_char_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  ils_char_if.sink              chars,
  input  wire logic             take,
  output logic                  item_valid,
  output ils_pkg::char_item_t   item
);
  import ils_pkg::*;

  logic item_valid_next;

  // The register may refill in the same cycle that its item moves on.
  assign chars.ready = !item_valid || take;

  always_comb begin
    item_valid_next = item_valid;
    if (chars.valid && chars.ready) begin
      item_valid_next = 1'b1;
    end else if (take) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item.ch          <= chars.ch;
      item.end_of_text <= chars.end_of_text;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ils_scan_logic.sv @@
// Next-state and result logic for one character of the literal scanner.
// Depends on ils_pkg.
`default_nettype none

module ils_scan_logic #(
  parameter int MAX_LENGTH = 255
) (
  input  wire ils_pkg::char_item_t  item,
  input  wire ils_pkg::scan_state_t cur,
  output ils_pkg::scan_state_t      nxt,
  output logic                      emit,
  output ils_pkg::result_t          result
);
  import ils_pkg::*;

  localparam int CAP_INT = (MAX_LENGTH > 255) ? 255 : MAX_LENGTH;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

  logic               digit;
  logic [4:0]         hexd;
  logic [LEN_W-1:0]   cnt_inc;
  logic [VALUE_W-1:0] dig_ext;
  logic [VALUE_W-1:0] acc10;
  logic [VALUE_W-1:0] acc16;
  logic               ok;
  logic [LEN_W-1:0]   emit_len;
  scan_state_t        idle_state;

  assign digit   = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign hexd    = hex_digit(item.ch);
  assign cnt_inc = (cur.consumed < LEN_CAP) ? cur.consumed + 1'b1 : cur.consumed;
  assign dig_ext = {{(VALUE_W-4){1'b0}}, item.ch[3:0]};
  assign acc10   = (cur.acc << 3) + (cur.acc << 1) + dig_ext;
  assign acc16   = {cur.acc[VALUE_W-5:0], hexd[3:0]};

  assign idle_state = '{mode: MODE_IDLE, negative: 1'b0, acc: '0, consumed: '0};

  always_comb begin
    nxt      = cur;
    emit     = 1'b0;
    ok       = 1'b0;
    emit_len = cur.consumed;
    unique case (cur.mode)
      MODE_SIGN: begin
        if (item.end_of_text || !digit) begin
          emit = 1'b1;
        end else begin
          nxt.acc      = dig_ext;
          nxt.consumed = cnt_inc;
          nxt.mode     = (item.ch == CH_ZERO) ? MODE_ZERO : MODE_DEC;
        end
      end
      MODE_ZERO, MODE_DEC: begin
        priority if (item.end_of_text) begin
          emit = 1'b1;
          ok   = 1'b1;
        end else if (cur.mode == MODE_ZERO && item.ch == CH_HEX_X) begin
          nxt.consumed = cnt_inc;
          nxt.acc      = '0;
          nxt.mode     = MODE_HEX;
        end else if (digit) begin
          nxt.acc      = acc10;
          nxt.consumed = cnt_inc;
          nxt.mode     = MODE_DEC;
        end else if (item.ch == CH_DOT) begin
          emit = 1'b1;
        end else if (item.ch == CH_LONG) begin
          emit     = 1'b1;
          ok       = 1'b1;
          emit_len = cnt_inc;
        end else begin
          emit = 1'b1;
          ok   = 1'b1;
        end
      end
      MODE_HEX: begin
        priority if (item.end_of_text) begin
          emit = 1'b1;
          ok   = 1'b1;
        end else if (hexd[4]) begin
          nxt.acc      = acc16;
          nxt.consumed = cnt_inc;
        end else begin
          emit = 1'b1;
          ok   = 1'b1;
          if (item.ch == CH_LONG) begin
            emit_len = cnt_inc;
          end
        end
      end
      default: begin
        // Idle, and any code that is not a mode, starts from a clean state.
        nxt = idle_state;
        priority if (item.end_of_text) begin
          emit = 1'b1;
        end else if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
          nxt.negative = (item.ch == CH_MINUS);
          nxt.consumed = LEN_W'(1);
          nxt.mode     = MODE_SIGN;
        end else if (digit) begin
          nxt.acc      = dig_ext;
          nxt.consumed = LEN_W'(1);
          nxt.mode     = (item.ch == CH_ZERO) ? MODE_ZERO : MODE_DEC;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (emit) begin
      nxt = idle_state;
    end
  end

  always_comb begin
    result.accepted = ok;
    result.value    = '0;
    result.length   = '0;
    if (ok) begin
      result.value  = cur.negative ? -$signed(cur.acc) : $signed(cur.acc);
      result.length = emit_len;
    end
  end

endmodule

`default_nettype wire

@@ hdl/integer_literal_scanner_core.sv @@
// Integer literal scanner: one character per item in, one literal result per token out.
// The last character of a token passes the input register and is scanned, and its
// result is then held in the output register. Throughput: one character per cycle; a
// result that the sink has not taken holds the scan stage and the input until it leaves.
// Reset (synchronous, active high) empties both registers and leaves the scanner idle.
// Depends on ils_pkg, ils_char_if, ils_result_if, ils_char_stage and ils_scan_logic.
`default_nettype none

module integer_literal_scanner_core #(
  parameter int MAX_LENGTH = 255
) (
  input  wire logic clk,
  input  wire logic rst,
  ils_char_if.sink     chars,
  ils_result_if.source results
);
  import ils_pkg::*;

  localparam int CAP_INT = (MAX_LENGTH > 255) ? 255 : MAX_LENGTH;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

  logic        item_valid;
  char_item_t  item;
  logic        take;
  scan_state_t state;
  scan_state_t state_next;
  logic        emit;
  result_t     result;
  logic        out_valid;
  result_t     out_data;

  ils_char_stage u_char_stage (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ils_scan_logic #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_scan_logic (
    .item   (item),
    .cur    (state),
    .nxt    (state_next),
    .emit   (emit),
    .result (result)
  );

  // A character is scanned only when the result register has room for what it may emit.
  assign take = item_valid && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_IDLE, negative: 1'b0, acc: '0, consumed: '0};
    end else if (take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data <= result;
    end
  end

  assign results.valid    = out_valid;
  assign results.accepted = out_data.accepted;
  assign results.value    = out_data.value;
  assign results.length   = out_data.length;

  a_reject_is_zero : assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.accepted |-> results.value == 0 && results.length == 0)
    else $error("rejected item carries a value or length");

  a_accept_has_length : assert property (@(posedge clk) disable iff (rst)
    results.valid && results.accepted |-> results.length != 0)
    else $error("accepted item with zero length");

  a_length_capped : assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.length <= LEN_CAP)
    else $error("length above cap");

  a_idle_after_emit : assert property (@(posedge clk) disable iff (rst)
    take && emit |=> state.mode == MODE_IDLE && state.acc == 0 && state.consumed == 0)
    else $error("scanner not idle after a result");

endmodule

`default_nettype wire

@@ sim/integer_literal_scanner_core_test.sv @@
// Self-checking testbench for the integer literal scanner core: a directed table,
// then random tokens over four idle/stall phases, checked against the table and a predictor.
// Depends on ils_pkg, ils_char_if, ils_result_if and integer_literal_scanner_core.
`default_nettype none

module integer_literal_scanner_core_test;
  import ils_pkg::*;

  localparam int MAX_LENGTH   = 255;
  localparam int LEN_CAP      = (MAX_LENGTH > 255) ? 255 : MAX_LENGTH;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    result_t    want;
  } directed_row_t;

  localparam result_t REJECT = '0;

  // Rows marked typed carry their expected result; the rest use the predictor.
  directed_row_t directed_rows [24] = '{
    '{"a",        1'b0, 1'b1, REJECT},
    '{8'h00,      1'b1, 1'b1, REJECT},
    '{CH_MINUS,   1'b0, 1'b0, REJECT},
    '{"5",        1'b0, 1'b0, REJECT},
    '{8'hff,      1'b1, 1'b1, '{1'b1, -64'sd5, 8'd2}},
    '{CH_PLUS,    1'b0, 1'b0, REJECT},
    '{CH_HEX_X,   1'b0, 1'b1, REJECT},
    '{CH_ZERO,    1'b0, 1'b0, REJECT},
    '{CH_DOT,     1'b0, 1'b1, REJECT},
    '{CH_ZERO,    1'b0, 1'b0, REJECT},
    '{CH_HEX_X,   1'b0, 1'b0, REJECT},
    '{"g",        1'b0, 1'b1, '{1'b1, 64'sd0, 8'd2}},
    '{CH_ZERO,    1'b0, 1'b0, REJECT},
    '{CH_HEX_X,   1'b0, 1'b0, REJECT},
    '{"F",        1'b0, 1'b0, REJECT},
    '{"a",        1'b0, 1'b0, REJECT},
    '{CH_DOT,     1'b0, 1'b1, '{1'b1, 64'sd250, 8'd4}},
    '{"9",        1'b0, 1'b0, REJECT},
    '{CH_LONG,    1'b0, 1'b1, '{1'b1, 64'sd9, 8'd2}},
    '{"1",        1'b0, 1'b0, REJECT},
    '{"2",        1'b0, 1'b0, REJECT},
    '{CH_DOT,     1'b0, 1'b1, REJECT},
    '{"7",        1'b0, 1'b0, REJECT},
    '{8'h00,      1'b0, 1'b0, REJECT}
  };

  logic clk;
  logic rst;

  ils_char_if   chars_bus ();
  ils_result_if results_bus ();

  integer_literal_scanner_core #(
    .MAX_LENGTH(MAX_LENGTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_bus),
    .results(results_bus)
  );

  // Predictor state.
  logic [2:0]  scan_mode;
  logic        scan_negative;
  logic [63:0] scan_acc;
  logic [7:0]  scan_consumed;

  result_t    expected_literals [$];
  char_item_t token_chars [$];
  result_t    got_want;
  int         literal_errors = 0;
  int         chars_fed = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic scan_idle();
    scan_mode     = MODE_IDLE;
    scan_negative = 1'b0;
    scan_acc      = '0;
    scan_consumed = '0;
  endtask

  task automatic scan_count();
    if (scan_consumed < LEN_CAP) begin
      scan_consumed = scan_consumed + 8'd1;
    end
  endtask

  task automatic scan_finish(input logic ok, output result_t r);
    r = REJECT;
    if (ok) begin
      r.accepted = 1'b1;
      r.value    = scan_negative ? (64'd0 - scan_acc) : scan_acc;
      r.length   = scan_consumed;
    end
    scan_idle();
  endtask

  task automatic scan_first_digit(input logic [7:0] c);
    scan_acc = {60'd0, c[3:0]};
    scan_count();
    scan_mode = (c == CH_ZERO) ? MODE_ZERO : MODE_DEC;
  endtask

  // Advances the predictor by one character; has_lit says whether a result comes out.
  task automatic scan_char(input logic [7:0] c, input logic e,
                           output logic has_lit, output result_t r);
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nib;
    is_dec  = (c >= CH_ZERO && c <= CH_NINE);
    is_hex  = 1'b1;
    nib     = 4'd0;
    has_lit = 1'b1;
    r       = REJECT;
    if (is_dec) begin
      nib = c[3:0];
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      nib = 4'(c - CH_LOWER_A + 8'd10);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      nib = 4'(c - CH_UPPER_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    case (scan_mode)
      MODE_SIGN: begin
        if (e || !is_dec) begin
          scan_finish(1'b0, r);
        end else begin
          scan_first_digit(c);
          has_lit = 1'b0;
        end
      end
      MODE_ZERO, MODE_DEC: begin
        if (e) begin
          scan_finish(1'b1, r);
        end else if (scan_mode == MODE_ZERO && c == CH_HEX_X) begin
          scan_count();
          scan_acc  = '0;
          scan_mode = MODE_HEX;
          has_lit   = 1'b0;
        end else if (is_dec) begin
          scan_acc = scan_acc * 64'd10 + {60'd0, nib};
          scan_count();
          scan_mode = MODE_DEC;
          has_lit   = 1'b0;
        end else if (c == CH_DOT) begin
          scan_finish(1'b0, r);
        end else begin
          if (c == CH_LONG) begin
            scan_count();
          end
          scan_finish(1'b1, r);
        end
      end
      MODE_HEX: begin
        if (e) begin
          scan_finish(1'b1, r);
        end else if (is_hex) begin
          scan_acc = {scan_acc[59:0], nib};
          scan_count();
          has_lit = 1'b0;
        end else begin
          if (c == CH_LONG) begin
            scan_count();
          end
          scan_finish(1'b1, r);
        end
      end
      default: begin
        scan_idle();
        if (e) begin
          scan_finish(1'b0, r);
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          scan_negative = (c == CH_MINUS);
          scan_count();
          scan_mode = MODE_SIGN;
          has_lit   = 1'b0;
        end else if (is_dec) begin
          scan_first_digit(c);
          has_lit = 1'b0;
        end else begin
          scan_finish(1'b0, r);
        end
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic feed_char(input logic [7:0] c, input logic e,
                           input logic typed, input result_t want);
    logic    has_lit;
    result_t lit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      chars_bus.valid <= 1'b0;
      @(negedge clk);
    end
    chars_bus.valid       <= 1'b1;
    chars_bus.ch          <= c;
    chars_bus.end_of_text <= e;
    @(posedge clk);
    while (!chars_bus.ready) begin
      @(posedge clk);
    end
    scan_char(c, e, has_lit, lit);
    if (typed) begin
      expected_literals.push_back(want);
    end else if (has_lit) begin
      expected_literals.push_back(lit);
    end
    chars_fed++;
    @(negedge clk);
  endtask

  task automatic push_char(input logic [7:0] c, input logic e);
    char_item_t it;
    it.ch          = c;
    it.end_of_text = e;
    token_chars.push_back(it);
  endtask

  // Builds one token: mostly well-formed literals with random content and ending.
  task automatic build_token();
    int kind;
    int n;
    int d;
    int sel;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      push_char(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    end else begin
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
        push_char(CH_PLUS, 1'b0);
      end else if (sel == 1) begin
        push_char(CH_MINUS, 1'b0);
      end
      if (kind < 50) begin
        push_char(CH_ZERO, 1'b0);
        push_char(($urandom_range(0, 19) == 0) ? 8'h58 : CH_HEX_X, 1'b0);
        n = ($urandom_range(0, 59) == 0) ? $urandom_range(250, 290) : $urandom_range(0, 18);
        repeat (n) begin
          d = $urandom_range(0, 15);
          if (d < 10) begin
            push_char(CH_ZERO + 8'(d), 1'b0);
          end else if ($urandom_range(0, 1) == 0) begin
            push_char(CH_LOWER_A + 8'(d - 10), 1'b0);
          end else begin
            push_char(CH_UPPER_A + 8'(d - 10), 1'b0);
          end
        end
      end else if (kind < 56) begin
        // Broken start: whatever follows the sign, if any, is random.
        push_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        n = ($urandom_range(0, 59) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 22);
        repeat (n) begin
          push_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
      end
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        push_char(CH_LONG, 1'b0);
      end else if (sel < 4) begin
        push_char(CH_DOT, 1'b0);
      end else if (sel == 4) begin
        push_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_char(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    results_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      results_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (expected_literals.size() == 0) begin
        $display("%0t: unexpected result accepted=%0b value=%0d length=%0d", $time,
                 results_bus.accepted, results_bus.value, results_bus.length);
        literal_errors++;
      end else begin
        got_want = expected_literals.pop_front();
        if (results_bus.accepted !== got_want.accepted) begin
          $display("%0t: accepted mismatch, expected %0b actual %0b", $time,
                   got_want.accepted, results_bus.accepted);
          literal_errors++;
        end
        if (results_bus.value !== got_want.value) begin
          $display("%0t: value mismatch, expected %0d actual %0d", $time,
                   got_want.value, results_bus.value);
          literal_errors++;
        end
        if (results_bus.length !== got_want.length) begin
          $display("%0t: length mismatch, expected %0d actual %0d", $time,
                   got_want.length, results_bus.length);
          literal_errors++;
        end
      end
    end
  end

  initial begin
    char_item_t it;
    int         phase_start;
    rst                   = 1'b1;
    chars_bus.valid       = 1'b0;
    chars_bus.ch          = 8'h00;
    chars_bus.end_of_text = 1'b0;
    scan_idle();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      feed_char(directed_rows[i].ch, directed_rows[i].eot,
                directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      phase_start = chars_fed;
      while (chars_fed - phase_start < RANDOM_ITEMS / 4) begin
        build_token();
        while (token_chars.size() != 0) begin
          it = token_chars.pop_front();
          feed_char(it.ch, it.end_of_text, 1'b0, REJECT);
        end
      end
      if (ph == 0) begin
        // Hold the sender off until the scanner has delivered everything.
        chars_bus.valid <= 1'b0;
        while (expected_literals.size() != 0) begin
          @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
      end
    end

    // Close any token still open so that it is checked too.
    feed_char(8'h00, 1'b1, 1'b0, REJECT);
    chars_bus.valid <= 1'b0;
    while (expected_literals.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (literal_errors == 0 && expected_literals.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
